// ===== rtl/mrc_pkg.sv =====
package mrc_pkg;
  localparam int MOD_W = 64;
  localparam int EXP_W = 128;
  localparam int CFG_IDX_W = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_EXP_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_EXP_LOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_EXP_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_EXP_LOW = 3'd5;

  localparam logic [63:0] RST_BASE_FIRST = 64'd2;
  localparam logic [63:0] RST_BASE_SECOND = 64'd3;
  localparam logic [63:0] RST_FIRST_EXP_HIGH = 64'd32491504068;
  localparam logic [63:0] RST_FIRST_EXP_LOW = 64'd1576836336967928270;
  localparam logic [63:0] RST_SECOND_EXP_HIGH = 64'd20499856654;
  localparam logic [63:0] RST_SECOND_EXP_LOW = 64'd15553907544489643179;
endpackage

// ===== rtl/mrc_front.sv =====
// Takes commands, classifies the modulus and pushes into a small queue.
module mrc_front #(
  parameter int MOD_WIDTH = mrc_pkg::MOD_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [63:0]          in_modulus,
  output logic                 q_valid,
  output logic [MOD_WIDTH-1:0] q_mod,
  output logic                 q_bad,
  input  logic                 q_pop
);
  localparam int D = mrc_pkg::QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;

  logic [MOD_WIDTH-1:0] mem_mod [D];
  logic                 mem_bad [D];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic push;
  logic [MOD_WIDTH-1:0] m;

  assign m = in_modulus[MOD_WIDTH-1:0];
  assign busy = (cnt_r == (PW+1)'(D));
  assign push = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_mod = mem_mod[rp_r];
  assign q_bad = mem_bad[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(D-1)) ? '0 : wp_r + 1'b1;
    end
    if (q_pop) begin
      rp_nxt = (rp_r == PW'(D-1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !q_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_mod[wp_r] <= m;
      mem_bad[wp_r] <= (m < MOD_WIDTH'(2));
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(D)) else $error("queue count overflow");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push && !q_pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("push lost");
`endif
endmodule

// ===== rtl/mrc_mulmod.sv =====
// a*b mod m, one bit of b per cycle (double, then conditional add).
module mrc_mulmod #(
  parameter int MOD_WIDTH = mrc_pkg::MOD_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [MOD_WIDTH-1:0] a,
  input  logic [MOD_WIDTH-1:0] b,
  input  logic [MOD_WIDTH-1:0] m,
  output logic                 done,
  output logic [MOD_WIDTH-1:0] res
);
  localparam int CW = $clog2(MOD_WIDTH + 1);

  logic [MOD_WIDTH-1:0] acc_r, acc_nxt, b_r, a_r;
  logic [CW-1:0] cnt_r;
  logic run_r;
  logic [MOD_WIDTH:0] dbl, sum;
  logic [MOD_WIDTH-1:0] t;

  always_comb begin
    dbl = {acc_r, 1'b0};
    t = (dbl >= {1'b0, m}) ? MOD_WIDTH'(dbl - {1'b0, m}) : dbl[MOD_WIDTH-1:0];
    sum = {1'b0, t} + {1'b0, a_r};
    acc_nxt = t;
    if (b_r[MOD_WIDTH-1]) begin
      acc_nxt = (sum >= {1'b0, m}) ? MOD_WIDTH'(sum - {1'b0, m}) : sum[MOD_WIDTH-1:0];
    end
  end

  assign res = acc_r;
  assign done = run_r && (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (go) begin
      run_r <= 1'b1;
      cnt_r <= CW'(MOD_WIDTH);
    end else if (run_r) begin
      if (cnt_r == '0) run_r <= 1'b0;
      else cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc_r <= '0;
      a_r <= a;
      b_r <= b;
    end else if (run_r && cnt_r != '0) begin
      acc_r <= acc_nxt;
      b_r <= {b_r[MOD_WIDTH-2:0], 1'b0};
    end
  end
endmodule

// ===== rtl/mrc_powmod.sv =====
// Right-to-left square-and-multiply; acc and sq multiplies run side by side.
module mrc_powmod #(
  parameter int MOD_WIDTH = mrc_pkg::MOD_W,
  parameter int EXP_WIDTH = mrc_pkg::EXP_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [63:0]          base,
  input  logic [127:0]         expo,
  input  logic [MOD_WIDTH-1:0] m,
  output logic                 done,
  output logic [MOD_WIDTH-1:0] res
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam int BW = (64 > MOD_WIDTH) ? 64 : MOD_WIDTH;
  localparam int CW = $clog2(EXP_WIDTH + 1);
  localparam int RW = $clog2(BW + 1);

  logic [2:0] st_r;
  logic [MOD_WIDTH-1:0] acc_r, sq_r;
  logic [EXP_WIDTH-1:0] e_r;
  logic [CW-1:0] bit_r;
  // base % m by restoring division, one bit a cycle
  logic [BW-1:0] rem_r, bq_r;
  logic [RW-1:0] rc_r;
  logic [BW:0] rsh;
  logic mgo, d0, d1;
  logic [MOD_WIDTH-1:0] p0, p1;

  assign rsh = {rem_r, bq_r[BW-1]};
  assign mgo = (st_r == S_MUL);
  assign done = (st_r == S_DONE);
  assign res = acc_r;

  mrc_mulmod #(.MOD_WIDTH(MOD_WIDTH)) u_macc (
    .clk(clk), .rst_n(rst_n), .go(mgo), .a(acc_r), .b(sq_r), .m(m),
    .done(d0), .res(p0));
  mrc_mulmod #(.MOD_WIDTH(MOD_WIDTH)) u_msq (
    .clk(clk), .rst_n(rst_n), .go(mgo), .a(sq_r), .b(sq_r), .m(m),
    .done(d1), .res(p1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: if (go) st_r <= S_RED;
        S_RED:  if (rc_r == '0) st_r <= S_MUL;
        S_MUL:  st_r <= S_WAIT;
        S_WAIT: if (d0) st_r <= (bit_r == CW'(1)) ? S_DONE : S_MUL;
        S_DONE: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        if (go) begin
          rem_r <= '0;
          bq_r <= BW'(base);
          rc_r <= RW'(BW);
          e_r <= expo[EXP_WIDTH-1:0];
          bit_r <= CW'(EXP_WIDTH);
          acc_r <= MOD_WIDTH'(1);
        end
      end
      S_RED: begin
        if (rc_r != '0) begin
          rem_r <= (rsh >= (BW+1)'(m)) ? BW'(rsh - (BW+1)'(m)) : rsh[BW-1:0];
          bq_r <= {bq_r[BW-2:0], 1'b0};
          rc_r <= rc_r - 1'b1;
        end else begin
          sq_r <= rem_r[MOD_WIDTH-1:0];
        end
      end
      S_WAIT: begin
        if (d0) begin
          if (e_r[0]) acc_r <= p0;
          sq_r <= p1;
          e_r <= e_r >> 1;
          bit_r <= bit_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    d0 == d1) else $error("multipliers out of step");
  a_acc_lt_m: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> acc_r < m) else $error("residue not reduced");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done held");
`endif
endmodule

// ===== rtl/mrc_back.sv =====
// Pops queued moduli, runs both powers and drives the result strobe.
module mrc_back #(
  parameter int MOD_WIDTH = mrc_pkg::MOD_W,
  parameter int EXP_WIDTH = mrc_pkg::EXP_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  logic [MOD_WIDTH-1:0] q_mod,
  input  logic                 q_bad,
  output logic                 q_pop,
  input  logic [63:0]          base_first,
  input  logic [63:0]          base_second,
  input  logic [127:0]         exp_first,
  input  logic [127:0]         exp_second,
  output logic                 out_valid,
  output logic [63:0]          out_modulus_echo,
  output logic [63:0]          out_residue_first,
  output logic [63:0]          out_residue_second,
  output logic                 out_divides,
  output logic                 out_bad_modulus
);
  logic run_r, go, d1, d2, got1_r, got2_r;
  logic [MOD_WIDTH-1:0] m_r, r1, r2, h1_r, h2_r;

  assign q_pop = q_valid && !run_r;
  assign go = q_pop && !q_bad;

  mrc_powmod #(.MOD_WIDTH(MOD_WIDTH), .EXP_WIDTH(EXP_WIDTH)) u_p1 (
    .clk(clk), .rst_n(rst_n), .go(go), .base(base_first), .expo(exp_first),
    .m(q_pop ? q_mod : m_r), .done(d1), .res(r1));
  mrc_powmod #(.MOD_WIDTH(MOD_WIDTH), .EXP_WIDTH(EXP_WIDTH)) u_p2 (
    .clk(clk), .rst_n(rst_n), .go(go), .base(base_second), .expo(exp_second),
    .m(q_pop ? q_mod : m_r), .done(d2), .res(r2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      out_valid <= 1'b0;
      got1_r <= 1'b0;
      got2_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (q_pop && q_bad) begin
        out_valid <= 1'b1;
      end else if (go) begin
        run_r <= 1'b1;
        got1_r <= 1'b0;
        got2_r <= 1'b0;
      end else if (run_r) begin
        if (d1) got1_r <= 1'b1;
        if (d2) got2_r <= 1'b1;
        if ((got1_r || d1) && (got2_r || d2)) begin
          run_r <= 1'b0;
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) m_r <= q_mod;
    if (d1) h1_r <= r1;
    if (d2) h2_r <= r2;
    if (q_pop && q_bad) begin
      out_modulus_echo <= 64'(q_mod);
      out_residue_first <= '0;
      out_residue_second <= '0;
      out_divides <= 1'b0;
      out_bad_modulus <= 1'b1;
    end else if (run_r && (got1_r || d1) && (got2_r || d2)) begin
      out_modulus_echo <= 64'(m_r);
      out_residue_first <= 64'(d1 ? r1 : h1_r);
      out_residue_second <= 64'(d2 ? r2 : h2_r);
      out_divides <= ((d1 ? r1 : h1_r) == (d2 ? r2 : h2_r));
      out_bad_modulus <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_running: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> !q_pop) else $error("pop while running");
  a_go_runs: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> run_r) else $error("engine not started");
  a_div_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_modulus |-> !out_divides) else $error("divides on bad modulus");
`endif
endmodule

// ===== rtl/modexp_residue_compare_top.sv =====
// Modular residue compare: for each modulus p computes
//   base_first^E1 mod p and base_second^E2 mod p, flags equality.
// Command channel: raise start with in_modulus; the transaction is taken
//   on a clock edge where start is high and busy is low. A two-entry queue
//   accepts commands while the engine works; busy is high when it is full.
// Result: out_valid pulses for one cycle with the fields; no backpressure.
// Config: cfg_valid/cfg_ready write cfg_index/cfg_data, always ready; write
//   only when idle. Indices beyond five are ignored.
// Engine: both powers run in parallel; the base is first reduced by
//   restoring division, then each exponent bit takes one pair of
//   bit-serial shift-and-add modular multiplies. A modulus below two
//   skips the powers and returns zero residues with bad_modulus set.
// Reset clears the queue, engine and configuration to default values.
module modexp_residue_compare_top #(
  parameter int MOD_WIDTH = mrc_pkg::MOD_W,
  parameter int EXP_WIDTH = mrc_pkg::EXP_W
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_modulus,
  output logic        out_valid,
  output logic [63:0] out_modulus_echo,
  output logic [63:0] out_residue_first,
  output logic [63:0] out_residue_second,
  output logic        out_divides,
  output logic        out_bad_modulus,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [mrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data
);
  logic [63:0] bf_r, bs_r, e1h_r, e1l_r, e2h_r, e2l_r;
  logic q_valid, q_bad, q_pop;
  logic [MOD_WIDTH-1:0] q_mod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bf_r <= mrc_pkg::RST_BASE_FIRST;
      bs_r <= mrc_pkg::RST_BASE_SECOND;
      e1h_r <= mrc_pkg::RST_FIRST_EXP_HIGH;
      e1l_r <= mrc_pkg::RST_FIRST_EXP_LOW;
      e2h_r <= mrc_pkg::RST_SECOND_EXP_HIGH;
      e2l_r <= mrc_pkg::RST_SECOND_EXP_LOW;
    end else if (cfg_valid) begin
      case (cfg_index)
        mrc_pkg::REG_BASE_FIRST:      bf_r <= cfg_data;
        mrc_pkg::REG_BASE_SECOND:     bs_r <= cfg_data;
        mrc_pkg::REG_FIRST_EXP_HIGH:  e1h_r <= cfg_data;
        mrc_pkg::REG_FIRST_EXP_LOW:   e1l_r <= cfg_data;
        mrc_pkg::REG_SECOND_EXP_HIGH: e2h_r <= cfg_data;
        mrc_pkg::REG_SECOND_EXP_LOW:  e2l_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mrc_front #(.MOD_WIDTH(MOD_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_modulus(in_modulus), .q_valid(q_valid), .q_mod(q_mod),
    .q_bad(q_bad), .q_pop(q_pop));

  mrc_back #(.MOD_WIDTH(MOD_WIDTH), .EXP_WIDTH(EXP_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_mod(q_mod),
    .q_bad(q_bad), .q_pop(q_pop), .base_first(bf_r), .base_second(bs_r),
    .exp_first({e1h_r, e1l_r}), .exp_second({e2h_r, e2l_r}),
    .out_valid(out_valid), .out_modulus_echo(out_modulus_echo),
    .out_residue_first(out_residue_first), .out_residue_second(out_residue_second),
    .out_divides(out_divides), .out_bad_modulus(out_bad_modulus));
endmodule

// ===== tb/sv/tb_modexp_residue_compare_top.sv =====
module tb_modexp_residue_compare_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [63:0] modulus;
    logic [63:0] res_a;
    logic [63:0] res_b;
    logic        divides;
    logic        bad;
  } residue_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] in_modulus = '0;
  logic        out_valid;
  logic [63:0] out_modulus_echo;
  logic [63:0] out_residue_first;
  logic [63:0] out_residue_second;
  logic        out_divides;
  logic        out_bad_modulus;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [mrc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [63:0]  base_a, base_b;
  logic [127:0] exp_a, exp_b;
  residue_t     pending_q[$];
  int           err_count = 0;
  int           cycles = 0;
  bit           gaps_on = 1'b1;

  modexp_residue_compare_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_modexp_residue_compare_top: done, errors");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h", what, got, want);
    err_count++;
  endtask

  function automatic logic [63:0] power_mod(input logic [63:0] b, input logic [127:0] e,
                                            input logic [63:0] m);
    logic [127:0] acc, sq;
    acc = 128'd1;
    sq  = {64'd0, b} % {64'd0, m};
    for (int i = 0; i < 128; i++) begin
      if (e[i]) acc = (acc * sq) % {64'd0, m};
      sq = (sq * sq) % {64'd0, m};
    end
    return acc[63:0];
  endfunction

  function automatic residue_t predict_residues(input logic [63:0] m);
    residue_t r;
    r.modulus = m;
    r.bad = (m < 64'd2);
    r.res_a = r.bad ? 64'd0 : power_mod(base_a, exp_a, m);
    r.res_b = r.bad ? 64'd0 : power_mod(base_b, exp_b, m);
    r.divides = !r.bad && (r.res_a == r.res_b);
    return r;
  endfunction

  // results cannot be held off: every strobe must match the oldest prediction
  always @(posedge clk) begin
    residue_t w;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        report("unexpected result", out_modulus_echo, 64'd0);
      end else begin
        w = pending_q.pop_front();
        if (out_modulus_echo !== w.modulus) report("modulus_echo", out_modulus_echo, w.modulus);
        if (out_residue_first !== w.res_a) report("residue_first", out_residue_first, w.res_a);
        if (out_residue_second !== w.res_b) report("residue_second", out_residue_second, w.res_b);
        if (out_divides !== w.divides) report("divides", 64'(out_divides), 64'(w.divides));
        if (out_bad_modulus !== w.bad) report("bad_modulus", 64'(out_bad_modulus), 64'(w.bad));
      end
    end
  end

  task automatic send_modulus(input logic [63:0] m);
    bit took;
    start <= 1'b1;
    in_modulus <= m;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
    pending_q.push_back(predict_residues(m));
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    wait (pending_q.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mrc_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    case (idx)
      mrc_pkg::REG_BASE_FIRST:      base_a = val;
      mrc_pkg::REG_BASE_SECOND:     base_b = val;
      mrc_pkg::REG_FIRST_EXP_HIGH:  exp_a[127:64] = val;
      mrc_pkg::REG_FIRST_EXP_LOW:   exp_a[63:0] = val;
      mrc_pkg::REG_SECOND_EXP_HIGH: exp_b[127:64] = val;
      mrc_pkg::REG_SECOND_EXP_LOW:  exp_b[63:0] = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [63:0] ba, input logic [63:0] bb,
                             input logic [127:0] ea, input logic [127:0] eb);
    write_reg(mrc_pkg::REG_BASE_FIRST, ba);
    write_reg(mrc_pkg::REG_BASE_SECOND, bb);
    write_reg(mrc_pkg::REG_FIRST_EXP_HIGH, ea[127:64]);
    write_reg(mrc_pkg::REG_FIRST_EXP_LOW, ea[63:0]);
    write_reg(mrc_pkg::REG_SECOND_EXP_HIGH, eb[127:64]);
    write_reg(mrc_pkg::REG_SECOND_EXP_LOW, eb[63:0]);
  endtask

  function automatic logic [63:0] rand_modulus();
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 40));
      1: return {32'd0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic test_reset_values;
    send_modulus(64'd0);
    send_modulus(64'd1);
    send_modulus(64'd2);
    send_modulus(64'd3);
    send_modulus(64'd97);
    send_modulus('1);
    send_modulus(64'h8000_0000_0000_0000);
    send_modulus(64'hFFFF_FFFF_FFFF_FFC5);  // largest 64-bit prime
    drain();
  endtask

  task automatic test_zero_exponent;
    load_config('1, 64'd0, 128'd0, 128'd0);
    send_modulus(64'd2);
    send_modulus(64'd1);
    send_modulus('1);
    send_modulus(64'd12345);
    drain();
  endtask

  task automatic test_equal_powers;
    // identical powers must always flag divides
    load_config('1, '1, '1, '1);
    send_modulus('1);
    send_modulus(64'hFFFF_FFFF_FFFF_FFFE);
    send_modulus(64'd7);
    drain();
  endtask

  task automatic test_bad_index;
    write_reg(3'd6, 64'hDEAD_BEEF);
    write_reg(3'd7, '1);
    send_modulus(64'd1000003);
    send_modulus(64'd0);
    drain();
  endtask

  task automatic test_random_phase(input int n, input int shape);
    logic [127:0] ea, eb;
    logic [63:0] ba, bb;
    ba = {$urandom(), $urandom()};
    bb = {$urandom(), $urandom()};
    ea = {$urandom(), $urandom(), $urandom(), $urandom()};
    eb = {$urandom(), $urandom(), $urandom(), $urandom()};
    if (shape == 1) begin
      ea = 128'($urandom_range(0, 300));
      eb = 128'($urandom_range(0, 300));
      ba = 64'($urandom_range(0, 9));
      bb = 64'($urandom_range(0, 9));
    end else if (shape == 2) begin
      bb = ba;
      eb = ea;
    end
    load_config(ba, bb, ea, eb);
    repeat (n) send_modulus(rand_modulus());
    drain();
  endtask

  initial begin
    base_a = mrc_pkg::RST_BASE_FIRST;
    base_b = mrc_pkg::RST_BASE_SECOND;
    exp_a = {mrc_pkg::RST_FIRST_EXP_HIGH, mrc_pkg::RST_FIRST_EXP_LOW};
    exp_b = {mrc_pkg::RST_SECOND_EXP_HIGH, mrc_pkg::RST_SECOND_EXP_LOW};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_zero_exponent();
    test_equal_powers();
    test_bad_index();
    test_random_phase(20, 0);
    test_random_phase(20, 1);
    test_random_phase(20, 2);
    test_random_phase(20, 0);
    gaps_on = 1'b0;
    test_random_phase(20, 1);
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("tb_modexp_residue_compare_top: done, clean");
    else
      $display("tb_modexp_residue_compare_top: done, errors");
    $finish;
  end
endmodule
